>>> hw/rtl/tbbe_pkg.sv
// Shared types, constants and basis tables for the triangle Bernstein basis evaluator.
package tbbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = FRAC_BITS + 1;
  localparam int VW        = 20;
  localparam int IDXW      = 4;
  localparam int DEGW      = 3;
  localparam int OPW       = 2;
  localparam int KW        = 5;
  localparam int PW        = CW + KW;
  localparam int NSTAGE    = 4;
  localparam int SELW      = 2 * NSTAGE;
  localparam int DEG_MAX_DEFAULT = 4;

  localparam logic [CW-1:0] ONE_Q = CW'(1) << FRAC_BITS;

  typedef enum logic [OPW-1:0] {
    OP_VALUE = 2'd0,
    OP_DS    = 2'd1,
    OP_DT    = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SEL_ONE = 2'd0,
    SEL_B1  = 2'd1,
    SEL_B2  = 2'd2,
    SEL_B3  = 2'd3
  } sel_e;

  typedef logic [CW-1:0] q_t;

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic            last;
    logic            outside;
  } tag_t;

  typedef struct packed {
    q_t              acc;
    logic [SELW-1:0] sel;
    logic [KW-1:0]   k;
  } lane_t;

  typedef struct packed {
    tag_t  tag;
    q_t    b1;
    q_t    b2;
    q_t    b3;
    lane_t plus;
    lane_t minus;
  } pipe_t;

  typedef struct packed {
    logic [2:0] i;
    logic [2:0] j;
    logic [2:0] k;
    logic [3:0] c;
  } ent_t;

  // Number of basis functions for a degree of 1 to 4.
  function automatic logic [IDXW-1:0] basis_count(input logic [DEGW-1:0] deg);
    logic [IDXW-1:0] n;
    case (deg)
      3'd1:    n = 4'd3;
      3'd2:    n = 4'd6;
      3'd3:    n = 4'd10;
      default: n = 4'd15;
    endcase
    return n;
  endfunction

  // Exponents and multinomial coefficient of one basis function.
  function automatic ent_t basis_entry(input logic [DEGW-1:0] deg,
                                       input logic [IDXW-1:0] idx);
    ent_t e;
    e = '{i: 3'd0, j: 3'd0, k: 3'd0, c: 4'd0};
    case ({deg, idx})
      {3'd1, 4'd0}:  e = '{3'd1, 3'd0, 3'd0, 4'd1};
      {3'd1, 4'd1}:  e = '{3'd0, 3'd1, 3'd0, 4'd1};
      {3'd1, 4'd2}:  e = '{3'd0, 3'd0, 3'd1, 4'd1};
      {3'd2, 4'd0}:  e = '{3'd2, 3'd0, 3'd0, 4'd1};
      {3'd2, 4'd1}:  e = '{3'd0, 3'd2, 3'd0, 4'd1};
      {3'd2, 4'd2}:  e = '{3'd0, 3'd0, 3'd2, 4'd1};
      {3'd2, 4'd3}:  e = '{3'd0, 3'd1, 3'd1, 4'd2};
      {3'd2, 4'd4}:  e = '{3'd1, 3'd0, 3'd1, 4'd2};
      {3'd2, 4'd5}:  e = '{3'd1, 3'd1, 3'd0, 4'd2};
      {3'd3, 4'd0}:  e = '{3'd3, 3'd0, 3'd0, 4'd1};
      {3'd3, 4'd1}:  e = '{3'd0, 3'd3, 3'd0, 4'd1};
      {3'd3, 4'd2}:  e = '{3'd0, 3'd0, 3'd3, 4'd1};
      {3'd3, 4'd3}:  e = '{3'd0, 3'd2, 3'd1, 4'd3};
      {3'd3, 4'd4}:  e = '{3'd0, 3'd1, 3'd2, 4'd3};
      {3'd3, 4'd5}:  e = '{3'd1, 3'd0, 3'd2, 4'd3};
      {3'd3, 4'd6}:  e = '{3'd2, 3'd0, 3'd1, 4'd3};
      {3'd3, 4'd7}:  e = '{3'd2, 3'd1, 3'd0, 4'd3};
      {3'd3, 4'd8}:  e = '{3'd1, 3'd2, 3'd0, 4'd3};
      {3'd3, 4'd9}:  e = '{3'd1, 3'd1, 3'd1, 4'd6};
      {3'd4, 4'd0}:  e = '{3'd4, 3'd0, 3'd0, 4'd1};
      {3'd4, 4'd1}:  e = '{3'd0, 3'd4, 3'd0, 4'd1};
      {3'd4, 4'd2}:  e = '{3'd0, 3'd0, 3'd4, 4'd1};
      {3'd4, 4'd3}:  e = '{3'd0, 3'd3, 3'd1, 4'd4};
      {3'd4, 4'd4}:  e = '{3'd0, 3'd2, 3'd2, 4'd6};
      {3'd4, 4'd5}:  e = '{3'd0, 3'd1, 3'd3, 4'd4};
      {3'd4, 4'd6}:  e = '{3'd1, 3'd0, 3'd3, 4'd4};
      {3'd4, 4'd7}:  e = '{3'd2, 3'd0, 3'd2, 4'd6};
      {3'd4, 4'd8}:  e = '{3'd3, 3'd0, 3'd1, 4'd4};
      {3'd4, 4'd9}:  e = '{3'd3, 3'd1, 3'd0, 4'd4};
      {3'd4, 4'd10}: e = '{3'd2, 3'd2, 3'd0, 4'd6};
      {3'd4, 4'd11}: e = '{3'd1, 3'd3, 3'd0, 4'd4};
      {3'd4, 4'd12}: e = '{3'd2, 3'd1, 3'd1, 4'd12};
      {3'd4, 4'd13}: e = '{3'd1, 3'd2, 3'd1, 4'd12};
      {3'd4, 4'd14}: e = '{3'd1, 3'd1, 3'd2, 4'd12};
      default:       e = '{3'd0, 3'd0, 3'd0, 4'd0};
    endcase
    return e;
  endfunction

  // Factor order for one monomial: b1 factors first, then b2, then b3.
  function automatic logic [SELW-1:0] factor_codes(input logic [2:0] i,
                                                   input logic [2:0] j,
                                                   input logic [2:0] k);
    logic [SELW-1:0] codes;
    logic [3:0]      p;
    codes = '0;
    for (int n = 0; n < NSTAGE; n++) begin
      p = 4'(n);
      if (p < {1'b0, i}) begin
        codes[2*n +: 2] = SEL_B1;
      end else if (p < ({1'b0, i} + {1'b0, j})) begin
        codes[2*n +: 2] = SEL_B2;
      end else if (p < ({1'b0, i} + {1'b0, j} + {1'b0, k})) begin
        codes[2*n +: 2] = SEL_B3;
      end else begin
        codes[2*n +: 2] = SEL_ONE;
      end
    end
    return codes;
  endfunction

endpackage

>>> hw/rtl/tbbe_seq.sv
// Input front end: degree register, point conditioning and per-function issue.
module tbbe_seq #(
  parameter int MAX_DEGREE = tbbe_pkg::DEG_MAX_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tbbe_pkg::DEGW-1:0]  cfg_degree_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tbbe_pkg::OPW-1:0]   opcode_i,
  input  logic [tbbe_pkg::CW-1:0]    s_coord_i,
  input  logic [tbbe_pkg::CW-1:0]    t_coord_i,
  output logic                       valid_o,
  output tbbe_pkg::pipe_t            pipe_o
);
  import tbbe_pkg::*;

  logic [DEGW-1:0] degree_q;
  logic            busy_q;
  op_e             op_q;
  q_t              b1_q, s_q, t_q;
  logic            outside_q;
  logic [DEGW-1:0] deg_q;
  logic [IDXW-1:0] idx_q;
  logic            valid_q;
  pipe_t           pipe_q;

  logic            accept, issue, is_last;
  logic [CW:0]     raw_sum, clip_sum;
  q_t              s_c, t_c, b1_c;
  logic [DEGW-1:0] deg_c;
  ent_t            ent;
  pipe_t           pipe_d;
  logic [2:0]      ei_m, ej_m, ek_m;

  assign cfg_ready_o = 1'b1;

  // Degree register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGW'(1);
    end else if (cfg_valid_i) begin
      degree_q <= cfg_degree_i;
    end
  end

  assign is_last    = (idx_q == basis_count(deg_q) - IDXW'(1));
  assign issue      = busy_q && adv_i;
  assign in_ready_o = !busy_q || (issue && is_last);
  assign accept     = in_valid_i && in_ready_o;

  // Point conditioning at the input transfer.
  always_comb begin
    raw_sum  = {1'b0, s_coord_i} + {1'b0, t_coord_i};
    s_c      = (s_coord_i > ONE_Q) ? ONE_Q : s_coord_i;
    t_c      = (t_coord_i > ONE_Q) ? ONE_Q : t_coord_i;
    clip_sum = {1'b0, s_c} + {1'b0, t_c};
    b1_c     = (clip_sum >= {1'b0, ONE_Q}) ? '0 : CW'({1'b0, ONE_Q} - clip_sum);
    if (cfg_degree_i == '0 && degree_q == '0) begin
      deg_c = DEGW'(1);
    end else if (degree_q == '0) begin
      deg_c = DEGW'(1);
    end else if (degree_q > DEGW'(MAX_DEGREE)) begin
      deg_c = DEGW'(MAX_DEGREE);
    end else begin
      deg_c = degree_q;
    end
  end

  // Item holding register and function counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (accept) begin
      busy_q <= (op_e'(opcode_i) != OP_NONE);
      idx_q  <= '0;
    end else if (issue) begin
      busy_q <= !is_last;
      idx_q  <= idx_q + IDXW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(opcode_i);
      s_q       <= s_c;
      t_q       <= t_c;
      b1_q      <= b1_c;
      outside_q <= (raw_sum > {1'b0, ONE_Q});
      deg_q     <= deg_c;
    end
  end

  // Build the two product lanes of the current function.
  always_comb begin
    ent  = basis_entry(deg_q, idx_q);
    ei_m = (ent.i != '0) ? ent.i - 3'd1 : '0;
    ej_m = (ent.j != '0) ? ent.j - 3'd1 : '0;
    ek_m = (ent.k != '0) ? ent.k - 3'd1 : '0;
    pipe_d.tag.idx     = idx_q;
    pipe_d.tag.last    = is_last;
    pipe_d.tag.outside = outside_q;
    pipe_d.b1          = b1_q;
    pipe_d.b2          = s_q;
    pipe_d.b3          = t_q;
    pipe_d.plus.acc    = ONE_Q;
    pipe_d.minus.acc   = ONE_Q;
    pipe_d.minus.sel   = factor_codes(ei_m, ent.j, ent.k);
    pipe_d.minus.k     = KW'(ent.c) * KW'(ent.i);
    case (op_q)
      OP_DS: begin
        pipe_d.plus.sel = factor_codes(ent.i, ej_m, ent.k);
        pipe_d.plus.k   = KW'(ent.c) * KW'(ent.j);
      end
      OP_DT: begin
        pipe_d.plus.sel = factor_codes(ent.i, ent.j, ek_m);
        pipe_d.plus.k   = KW'(ent.c) * KW'(ent.k);
      end
      default: begin
        pipe_d.plus.sel = factor_codes(ent.i, ent.j, ent.k);
        pipe_d.plus.k   = KW'(ent.c);
        pipe_d.minus.k  = '0;
      end
    endcase
  end

  // Issue register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

>>> hw/rtl/tbbe_mul_stage.sv
// One multiply stage: each lane takes its next barycentric factor and truncates.
module tbbe_mul_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  tbbe_pkg::pipe_t pipe_i,
  output logic            valid_o,
  output tbbe_pkg::pipe_t pipe_o
);
  import tbbe_pkg::*;

  logic  valid_q;
  pipe_t pipe_q, pipe_d;
  q_t    fac_p, fac_m;
  logic [2*CW-1:0] prod_p, prod_m;

  function automatic q_t pick(input logic [1:0] code, input pipe_t p);
    q_t f;
    case (sel_e'(code))
      SEL_B1:  f = p.b1;
      SEL_B2:  f = p.b2;
      SEL_B3:  f = p.b3;
      default: f = ONE_Q;
    endcase
    return f;
  endfunction

  // Multiply, truncate and advance the factor codes.
  always_comb begin
    fac_p  = pick(pipe_i.plus.sel[1:0], pipe_i);
    fac_m  = pick(pipe_i.minus.sel[1:0], pipe_i);
    prod_p = pipe_i.plus.acc * fac_p;
    prod_m = pipe_i.minus.acc * fac_m;
    pipe_d = pipe_i;
    pipe_d.plus.acc  = prod_p[FRAC_BITS +: CW];
    pipe_d.minus.acc = prod_m[FRAC_BITS +: CW];
    pipe_d.plus.sel  = pipe_i.plus.sel >> 2;
    pipe_d.minus.sel = pipe_i.minus.sel >> 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

>>> hw/rtl/tbbe_combine.sv
// Output stage: coefficient scaling, difference, saturation and output register.
module tbbe_combine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  tbbe_pkg::pipe_t               pipe_i,
  output logic                          out_valid_o,
  output logic [tbbe_pkg::IDXW-1:0]     basis_index_o,
  output logic signed [tbbe_pkg::VW-1:0] value_o,
  output logic                          last_o,
  output logic                          outside_o
);
  import tbbe_pkg::*;

  localparam logic signed [PW:0] LIMIT = (PW+1)'(4) <<< FRAC_BITS;

  logic                 valid_q;
  tag_t                 tag_q;
  logic signed [VW-1:0] value_q;
  logic [PW-1:0]        sc_p, sc_m;
  logic signed [PW:0]   diff, sat;

  // Scale both lanes and saturate the difference to plus or minus four.
  always_comb begin
    sc_p = PW'(pipe_i.plus.acc) * PW'(pipe_i.plus.k);
    sc_m = PW'(pipe_i.minus.acc) * PW'(pipe_i.minus.k);
    diff = $signed({1'b0, sc_p}) - $signed({1'b0, sc_m});
    if (diff > LIMIT) begin
      sat = LIMIT;
    end else if (diff < -LIMIT) begin
      sat = -LIMIT;
    end else begin
      sat = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q   <= pipe_i.tag;
      value_q <= sat[VW-1:0];
    end
  end

  assign out_valid_o   = valid_q;
  assign basis_index_o = tag_q.idx;
  assign value_o       = value_q;
  assign last_o        = tag_q.last;
  assign outside_o     = tag_q.outside;

endmodule

>>> hw/rtl/triangle_bernstein_basis_eval_top.sv
// Top level of the triangle Bernstein basis evaluator.
// Each accepted point (s, t) with an opcode produces one result per basis function of
// the configured degree, one result per clock while the output is not stalled, so a
// point yields 3, 6, 10 or 15 results for degree 1 to 4; opcode 3 is accepted and
// produces nothing. The issue counter in the front end sets that rate, and the next
// point is taken in the cycle its predecessor's final function is issued. Results
// pass through an issue register, four multiply stages and the output register.
// Write the degree only while the block is idle.
module triangle_bernstein_basis_eval_top #(
  parameter int MAX_DEGREE = tbbe_pkg::DEG_MAX_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tbbe_pkg::DEGW-1:0]      cfg_degree_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tbbe_pkg::OPW-1:0]       opcode_i,
  input  logic [tbbe_pkg::CW-1:0]        s_coord_i,
  input  logic [tbbe_pkg::CW-1:0]        t_coord_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tbbe_pkg::IDXW-1:0]      basis_index_o,
  output logic signed [tbbe_pkg::VW-1:0] value_o,
  output logic                           last_o,
  output logic                           outside_o
);
  import tbbe_pkg::*;

  logic  adv;
  logic  valid_s [NSTAGE+1];
  pipe_t pipe_s  [NSTAGE+1];

  // The whole pipeline moves unless a result waits at the output.
  assign adv = !out_valid_o || out_ready_i;

  tbbe_seq #(.MAX_DEGREE(MAX_DEGREE)) u_seq (
    .clk_i, .rst_ni, .adv_i(adv),
    .cfg_valid_i, .cfg_ready_o, .cfg_degree_i,
    .in_valid_i, .in_ready_o, .opcode_i, .s_coord_i, .t_coord_i,
    .valid_o(valid_s[0]), .pipe_o(pipe_s[0])
  );

  // Four factor stages.
  for (genvar g = 0; g < NSTAGE; g++) begin : g_mul
    tbbe_mul_stage u_mul (
      .clk_i, .rst_ni, .adv_i(adv),
      .valid_i(valid_s[g]), .pipe_i(pipe_s[g]),
      .valid_o(valid_s[g+1]), .pipe_o(pipe_s[g+1])
    );
  end

  tbbe_combine u_comb (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(valid_s[NSTAGE]), .pipe_i(pipe_s[NSTAGE]),
    .out_valid_o, .basis_index_o, .value_o, .last_o, .outside_o
  );

endmodule
